// ===== hw/rtl/intel_hex_record_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// intel hex record encoder assertion macros
// shared property wrappers, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_ENCODER_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_ASSERT_SVH

// checked only outside reset
`define IHEX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define IHEX_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// types, control word layout, codes and helpers of the hex record encoder
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int ROW_BYTES_DEF = 16;

    // step counter of the sequencer program
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    // program entry points and labels
    localparam t_step ST_ENTRY = 5'd0;
    localparam t_step ST_REC   = 5'd3;
    localparam t_step ST_DATA  = 5'd12;
    localparam t_step ST_CSUM  = 5'd14;
    localparam t_step ST_STORE = 5'd19;
    localparam t_step ST_FIN   = 5'd21;
    localparam t_step ST_EOF   = 5'd23;
    localparam t_step ST_END   = 5'd31;

    // character emitted by a step
    localparam logic [2:0] EM_NONE  = 3'd0;
    localparam logic [2:0] EM_COLON = 3'd1;
    localparam logic [2:0] EM_HI    = 3'd2;
    localparam logic [2:0] EM_LO    = 3'd3;
    localparam logic [2:0] EM_NL    = 3'd4;

    // record byte selected for hex output
    localparam logic [2:0] SRC_LEN  = 3'd0;
    localparam logic [2:0] SRC_AHI  = 3'd1;
    localparam logic [2:0] SRC_ALO  = 3'd2;
    localparam logic [2:0] SRC_TYPE = 3'd3;
    localparam logic [2:0] SRC_DATA = 3'd4;
    localparam logic [2:0] SRC_CSUM = 3'd5;

    // datapath actions, applied when the step retires
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_SET_ELA  = 3'd1;
    localparam logic [2:0] ACT_SET_DATA = 3'd2;
    localparam logic [2:0] ACT_SET_EOF  = 3'd3;
    localparam logic [2:0] ACT_SUM      = 3'd4;
    localparam logic [2:0] ACT_SUM_NEXT = 3'd5;
    localparam logic [2:0] ACT_REC_END  = 3'd6;
    localparam logic [2:0] ACT_STORE    = 3'd7;

    // jump conditions
    localparam logic [3:0] C_NEVER    = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_FINISH   = 4'd2;
    localparam logic [3:0] C_NO_ELA   = 4'd3;
    localparam logic [3:0] C_LEN_ZERO = 4'd4;
    localparam logic [3:0] C_IDX_MORE = 4'd5;
    localparam logic [3:0] C_REC_DONE = 4'd6;
    localparam logic [3:0] C_REC_ELA  = 4'd7;
    localparam logic [3:0] C_NOT_FULL = 4'd8;
    localparam logic [3:0] C_CNT_ZERO = 4'd9;

    // record types
    typedef logic [2:0] t_rec;
    localparam t_rec REC_DATA = 3'h0;
    localparam t_rec REC_EOF  = 3'h1;
    localparam t_rec REC_ELA  = 3'h4;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    typedef struct packed {
        logic [2:0] emit;
        logic [2:0] src;
        logic [2:0] act;
        logic [3:0] cond;
        t_step      target;
    } t_ctrl;

    typedef struct packed {
        logic fin;
        logic no_ela;
        logic len_zero;
        logic idx_more;
        logic rec_done;
        logic rec_ela;
        logic not_full;
        logic cnt_zero;
    } t_stat;

    typedef struct packed {
        logic start;
        logic adv;
    } t_seq_ev;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/ihex_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// ihex_ucode_rom
// control store: one control word per program step
// ----------------------------------------------------------------------------
module ihex_ucode_rom (
    input  ihex_pkg::t_step i_pc,
    output ihex_pkg::t_ctrl o_cw
);
    import ihex_pkg::*;

    function automatic t_ctrl cw(input logic [2:0] emit, input logic [2:0] src,
                                 input logic [2:0] act, input logic [3:0] cond,
                                 input t_step target);
        t_ctrl w;
        w.emit   = emit;
        w.src    = src;
        w.act    = act;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    always_comb begin
        case (i_pc)
            // dispatch
            5'd0:  o_cw = cw(EM_NONE,  SRC_LEN,  ACT_NONE,     C_FINISH,   ST_FIN);
            5'd1:  o_cw = cw(EM_NONE,  SRC_LEN,  ACT_NONE,     C_NO_ELA,   ST_STORE);
            5'd2:  o_cw = cw(EM_NONE,  SRC_LEN,  ACT_SET_ELA,  C_NEVER,    ST_ENTRY);
            // record body
            5'd3:  o_cw = cw(EM_COLON, SRC_LEN,  ACT_NONE,     C_NEVER,    ST_ENTRY);
            5'd4:  o_cw = cw(EM_HI,    SRC_LEN,  ACT_NONE,     C_NEVER,    ST_ENTRY);
            5'd5:  o_cw = cw(EM_LO,    SRC_LEN,  ACT_SUM,      C_NEVER,    ST_ENTRY);
            5'd6:  o_cw = cw(EM_HI,    SRC_AHI,  ACT_NONE,     C_NEVER,    ST_ENTRY);
            5'd7:  o_cw = cw(EM_LO,    SRC_AHI,  ACT_SUM,      C_NEVER,    ST_ENTRY);
            5'd8:  o_cw = cw(EM_HI,    SRC_ALO,  ACT_NONE,     C_NEVER,    ST_ENTRY);
            5'd9:  o_cw = cw(EM_LO,    SRC_ALO,  ACT_SUM,      C_NEVER,    ST_ENTRY);
            5'd10: o_cw = cw(EM_HI,    SRC_TYPE, ACT_NONE,     C_NEVER,    ST_ENTRY);
            5'd11: o_cw = cw(EM_LO,    SRC_TYPE, ACT_SUM,      C_LEN_ZERO, ST_CSUM);
            5'd12: o_cw = cw(EM_HI,    SRC_DATA, ACT_NONE,     C_NEVER,    ST_ENTRY);
            5'd13: o_cw = cw(EM_LO,    SRC_DATA, ACT_SUM_NEXT, C_IDX_MORE, ST_DATA);
            5'd14: o_cw = cw(EM_HI,    SRC_CSUM, ACT_NONE,     C_NEVER,    ST_ENTRY);
            5'd15: o_cw = cw(EM_LO,    SRC_CSUM, ACT_NONE,     C_NEVER,    ST_ENTRY);
            5'd16: o_cw = cw(EM_NL,    SRC_LEN,  ACT_REC_END,  C_REC_DONE, ST_END);
            // after a record that does not end the item
            5'd17: o_cw = cw(EM_NONE,  SRC_LEN,  ACT_NONE,     C_REC_ELA,  ST_STORE);
            5'd18: o_cw = cw(EM_NONE,  SRC_LEN,  ACT_NONE,     C_ALWAYS,   ST_EOF);
            // data byte into the row
            5'd19: o_cw = cw(EM_NONE,  SRC_LEN,  ACT_STORE,    C_NOT_FULL, ST_END);
            5'd20: o_cw = cw(EM_NONE,  SRC_LEN,  ACT_SET_DATA, C_ALWAYS,   ST_REC);
            // finish
            5'd21: o_cw = cw(EM_NONE,  SRC_LEN,  ACT_NONE,     C_CNT_ZERO, ST_EOF);
            5'd22: o_cw = cw(EM_NONE,  SRC_LEN,  ACT_SET_DATA, C_ALWAYS,   ST_REC);
            5'd23: o_cw = cw(EM_NONE,  SRC_LEN,  ACT_SET_EOF,  C_ALWAYS,   ST_REC);
            default: o_cw = cw(EM_NONE, SRC_LEN, ACT_NONE,     C_ALWAYS,   ST_END);
        endcase
    end

endmodule

// ===== hw/rtl/ihex_seq.sv =====
// ----------------------------------------------------------------------------
// ihex_seq
// step counter, jump logic and channel handshakes
// ----------------------------------------------------------------------------
module ihex_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_last,
    input  ihex_pkg::t_ctrl   i_cw,
    input  ihex_pkg::t_stat   i_stat,
    output ihex_pkg::t_step   o_pc,
    output ihex_pkg::t_seq_ev o_ev
);
    import ihex_pkg::*;
    `include "intel_hex_record_encoder_assert.svh"

    localparam logic SQ_IDLE = 1'b0;
    localparam logic SQ_RUN  = 1'b1;

    logic  r_state, n_state;
    t_step r_pc, n_pc;
    t_step next_pc;
    logic  cond_hit;
    logic  emitting;

    always_comb begin
        case (i_cw.cond)
            C_NEVER:    cond_hit = 1'b0;
            C_ALWAYS:   cond_hit = 1'b1;
            C_FINISH:   cond_hit = i_stat.fin;
            C_NO_ELA:   cond_hit = i_stat.no_ela;
            C_LEN_ZERO: cond_hit = i_stat.len_zero;
            C_IDX_MORE: cond_hit = i_stat.idx_more;
            C_REC_DONE: cond_hit = i_stat.rec_done;
            C_REC_ELA:  cond_hit = i_stat.rec_ela;
            C_NOT_FULL: cond_hit = i_stat.not_full;
            C_CNT_ZERO: cond_hit = i_stat.cnt_zero;
            default:    cond_hit = 1'b1;
        endcase
    end

    assign next_pc     = cond_hit ? i_cw.target : r_pc + t_step'(1);
    assign emitting    = (i_cw.emit != EM_NONE);
    assign o_in_ready  = (r_state == SQ_IDLE);
    assign o_out_valid = (r_state == SQ_RUN) && emitting;
    assign o_out_last  = emitting && (next_pc == ST_END);
    assign o_ev.start  = i_in_valid && o_in_ready;
    // internal steps retire every cycle, character steps on the output handshake
    assign o_ev.adv    = (r_state == SQ_RUN) && (!emitting || i_out_ready);
    assign o_pc        = r_pc;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        if (o_ev.start) begin
            n_state = SQ_RUN;
            n_pc    = ST_ENTRY;
        end else if (o_ev.adv) begin
            n_pc = next_pc;
            if (next_pc == ST_END) begin
                n_state = SQ_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_pc    <= ST_ENTRY;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    `IHEX_ASSERT(a_no_out_when_idle, o_in_ready |-> !o_out_valid, "output while idle")
    `IHEX_ASSERT(a_busy_after_accept, o_ev.start |=> !o_in_ready, "not busy after accept")
    `IHEX_ASSERT(a_idle_after_last, (o_out_valid && i_out_ready && o_out_last) |=> o_in_ready,
                 "not idle after last character")
    `IHEX_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (o_in_ready && !o_out_valid),
                        "not idle after reset")

endmodule

// ===== hw/rtl/ihex_dp.sv =====
// ----------------------------------------------------------------------------
// ihex_dp
// row buffer, address state, checksum and character generation
// ----------------------------------------------------------------------------
module ihex_dp #(
    parameter int ROW_BYTES = ihex_pkg::ROW_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    input  ihex_pkg::t_ctrl   i_cw,
    input  ihex_pkg::t_seq_ev i_ev,
    output ihex_pkg::t_stat   o_stat,
    output logic [7:0]        o_text_char
);
    import ihex_pkg::*;

    localparam int CW = $clog2(ROW_BYTES + 1);
    localparam int AW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

    logic [31:0]   r_base, n_base;
    logic [31:0]   r_row_addr, n_row_addr;
    logic [15:0]   r_ann, n_ann;
    logic          r_uv, n_uv;
    logic [CW-1:0] r_cnt, n_cnt;
    t_rec          r_rec, n_rec;
    logic [7:0]    r_len, n_len;
    logic [CW-1:0] r_idx, n_idx;
    logic [7:0]    r_sum, n_sum;
    logic          r_op;
    logic [7:0]    r_byte;
    logic [7:0]    r_row [ROW_BYTES];
    logic [7:0]    sel_byte;
    logic          do_act;
    logic          ela_store;
    logic          row_we;

    assign do_act = i_ev.adv;

    // the byte that opened an address record is stored as that record ends
    assign ela_store = (i_cw.act == ACT_REC_END) && (r_rec == REC_ELA) && (ROW_BYTES > 1);
    assign row_we    = do_act && ((i_cw.act == ACT_STORE) || ela_store);

    always_comb begin
        case (i_cw.src)
            SRC_LEN:  sel_byte = r_len;
            SRC_AHI:  sel_byte = (r_rec == REC_DATA) ? r_row_addr[15:8] : 8'h00;
            SRC_ALO:  sel_byte = (r_rec == REC_DATA) ? r_row_addr[7:0] : 8'h00;
            SRC_TYPE: sel_byte = 8'(r_rec);
            SRC_DATA: begin
                if (r_rec == REC_ELA) begin
                    sel_byte = (r_idx == '0) ? r_ann[15:8] : r_ann[7:0];
                end else begin
                    sel_byte = r_row[r_idx[AW-1:0]];
                end
            end
            SRC_CSUM: sel_byte = ~r_sum + 8'd1;
            default:  sel_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (i_cw.emit)
            EM_COLON: o_text_char = CHAR_COLON;
            EM_HI:    o_text_char = hex_char(sel_byte[7:4]);
            EM_LO:    o_text_char = hex_char(sel_byte[3:0]);
            EM_NL:    o_text_char = CHAR_NL;
            default:  o_text_char = 8'h00;
        endcase
    end

    always_comb begin
        o_stat.fin      = r_op;
        o_stat.no_ela   = !((r_cnt == '0) && (!r_uv || (r_row_addr[31:16] != r_ann)));
        o_stat.len_zero = (r_len == 8'd0);
        o_stat.idx_more = ((8'(r_idx) + 8'd1) < r_len);
        o_stat.rec_done = (r_rec == REC_EOF) || ((r_rec == REC_DATA) && !r_op) ||
                          ((r_rec == REC_ELA) && (ROW_BYTES > 1));
        o_stat.rec_ela  = (r_rec == REC_ELA);
        o_stat.not_full = ((8'(r_cnt) + 8'd1) < 8'(ROW_BYTES));
        o_stat.cnt_zero = (r_cnt == '0);
    end

    always_comb begin
        n_base     = r_base;
        n_row_addr = r_row_addr;
        n_ann      = r_ann;
        n_uv       = r_uv;
        n_cnt      = r_cnt;
        n_rec      = r_rec;
        n_len      = r_len;
        n_idx      = r_idx;
        n_sum      = r_sum;
        if (i_cfg_we) begin
            n_base = i_cfg_wdata;
            // relocate at once when no row is pending
            if (r_cnt == '0) begin
                n_row_addr = i_cfg_wdata;
            end
        end
        if (do_act) begin
            case (i_cw.act)
                ACT_SET_ELA: begin
                    n_rec = REC_ELA;
                    n_len = 8'd2;
                    n_ann = r_row_addr[31:16];
                    n_uv  = 1'b1;
                    n_idx = '0;
                    n_sum = 8'd0;
                end
                ACT_SET_DATA: begin
                    n_rec = REC_DATA;
                    n_len = 8'(r_cnt);
                    n_idx = '0;
                    n_sum = 8'd0;
                end
                ACT_SET_EOF: begin
                    n_rec      = REC_EOF;
                    n_len      = 8'd0;
                    n_row_addr = r_base;
                    n_uv       = 1'b0;
                    n_idx      = '0;
                    n_sum      = 8'd0;
                end
                ACT_SUM: begin
                    n_sum = r_sum + sel_byte;
                end
                ACT_SUM_NEXT: begin
                    n_sum = r_sum + sel_byte;
                    n_idx = r_idx + CW'(1);
                end
                ACT_REC_END: begin
                    if (r_rec == REC_DATA) begin
                        n_row_addr = r_row_addr + 32'(r_len);
                        n_cnt      = '0;
                    end else if (ela_store) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                ACT_STORE: begin
                    n_cnt = r_cnt + CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= 32'd0;
            r_row_addr <= 32'd0;
            r_ann      <= 16'd0;
            r_uv       <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_base     <= n_base;
            r_row_addr <= n_row_addr;
            r_ann      <= n_ann;
            r_uv       <= n_uv;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        r_len <= n_len;
        r_idx <= n_idx;
        r_sum <= n_sum;
        if (i_ev.start) begin
            r_op   <= i_op;
            r_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row[r_cnt[AW-1:0]] <= r_byte;
        end
    end

endmodule

// ===== hw/rtl/intel_hex_record_encoder.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_encoder
// byte stream to intel hex (i32hex) text, one ascii character per output item
//
//   channel   signals                               meaning
//   in        i_in_valid/o_in_ready, i_op,          data byte or finish command
//             i_data_byte
//   out       o_out_valid/i_out_ready,              record text character,
//             o_text_char, o_last                   last marks end of an item's text
//   cfg       i_cfg_we, i_cfg_wdata                 base load address
//
// one item at a time: accept, then the program runs 3 to 6 internal steps
// plus one step per character; a full 16-byte row record is 44 characters.
// characters leave one at a time through the single output port of the
// sequencer. a stalled output holds the current step; reset is synchronous
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder #(
    parameter int ROW_BYTES = ihex_pkg::ROW_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_text_char,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import ihex_pkg::*;

    t_step   pc;
    t_ctrl   cw;
    t_stat   stat;
    t_seq_ev ev;

    ihex_ucode_rom u_rom (
        .i_pc (pc),
        .o_cw (cw)
    );

    ihex_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_last  (o_last),
        .i_cw        (cw),
        .i_stat      (stat),
        .o_pc        (pc),
        .o_ev        (ev)
    );

    ihex_dp #(
        .ROW_BYTES (ROW_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_cw        (cw),
        .i_ev        (ev),
        .o_stat      (stat),
        .o_text_char (o_text_char)
    );

endmodule

// ===== sim/intel_hex_record_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_tb
// drives data bytes and finish commands into the hex record encoder under
// random handshake idling and base address changes between phases, predicts
// every record character and checks the text stream character by character
// ----------------------------------------------------------------------------
module intel_hex_record_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LEN     = ihex_pkg::ROW_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 60;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] TYPE_DATA = {5'd0, ihex_pkg::REC_DATA};
    localparam logic [7:0] TYPE_EOF  = {5'd0, ihex_pkg::REC_EOF};
    localparam logic [7:0] TYPE_ELA  = {5'd0, ihex_pkg::REC_ELA};

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } t_text_exp;

    typedef logic [7:0] t_bytes [$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_op = OP_BYTE;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_text_char;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = 32'd0;

    // stimulus and expected text
    t_item     pend_q [$];
    t_text_exp text_q [$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    int        send_gap = 0;
    int        stall_left = 0;

    // encoder state as predicted
    logic [31:0] load_base = 32'd0;
    logic [31:0] row_addr = 32'd0;
    logic [15:0] shown_upper = 16'd0;
    bit          upper_shown = 1'b0;
    t_bytes      row_buf;

    intel_hex_record_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_text_char (o_text_char),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] ascii_nibble(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
    endfunction

    task automatic emit_char(input logic [7:0] c);
        t_text_exp e;
        e.ch = c;
        e.is_last = 1'b0;
        text_q.push_back(e);
    endtask

    task automatic emit_hex(input logic [7:0] v);
        emit_char(ascii_nibble(v[7:4]));
        emit_char(ascii_nibble(v[3:0]));
    endtask

    task automatic emit_record(input logic [7:0] rtype, input logic [15:0] addr,
                               input t_bytes body);
        logic [7:0] len;
        logic [7:0] sum;
        len = 8'(body.size());
        sum = len + addr[15:8] + addr[7:0] + rtype;
        emit_char(ihex_pkg::CHAR_COLON);
        emit_hex(len);
        emit_hex(addr[15:8]);
        emit_hex(addr[7:0]);
        emit_hex(rtype);
        foreach (body[i]) begin
            sum = sum + body[i];
            emit_hex(body[i]);
        end
        emit_hex(8'd0 - sum);
        emit_char(ihex_pkg::CHAR_NL);
    endtask

    task automatic flush_row();
        emit_record(TYPE_DATA, row_addr[15:0], row_buf);
        row_addr = row_addr + 32'(row_buf.size());
        row_buf.delete();
    endtask

    // text caused by one accepted item
    task automatic encode_item(input logic op, input logic [7:0] data);
        int        mark;
        t_bytes    ela;
        t_bytes    none;
        logic [15:0] upper;
        t_text_exp tail;
        mark = text_q.size();
        if (op == OP_BYTE) begin
            if (row_buf.size() == 0) begin
                upper = row_addr[31:16];
                if (!upper_shown || upper != shown_upper) begin
                    ela.push_back(upper[15:8]);
                    ela.push_back(upper[7:0]);
                    emit_record(TYPE_ELA, 16'd0, ela);
                    shown_upper = upper;
                    upper_shown = 1'b1;
                end
            end
            row_buf.push_back(data);
            if (row_buf.size() >= ROW_LEN) begin
                flush_row();
            end
        end else begin
            if (row_buf.size() != 0) begin
                flush_row();
            end
            emit_record(TYPE_EOF, 16'd0, none);
            row_addr = load_base;
            upper_shown = 1'b0;
        end
        if (text_q.size() > mark) begin
            tail = text_q.pop_back();
            tail.is_last = 1'b1;
            text_q.push_back(tail);
        end
    endtask

    task automatic queue_item(input logic op, input logic [7:0] data);
        t_item it;
        it.op = op;
        it.data = data;
        pend_q.push_back(it);
    endtask

    // wait until the encoder has nothing in flight
    task automatic settle();
        while (pend_q.size() != 0 || i_in_valid || text_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        load_base = v;
        if (row_buf.size() == 0) begin
            row_addr = v;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int n, input int finish_odds);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, finish_odds - 1) == 0) begin
                queue_item(OP_FINISH, 8'($urandom_range(0, 255)));
            end else begin
                queue_item(OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // driver: input items and output back-pressure
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    it = pend_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_op <= it.op;
                    i_data_byte <= it.data;
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 15);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
                stall_left = $urandom_range(0, 14);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor: check text, then predict for the item taken at this edge
    always @(posedge i_clk) begin
        t_text_exp want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (text_q.size() == 0) begin
                    $error("unexpected character: text_char %h last %b",
                           o_text_char, o_last);
                    errors++;
                end else begin
                    want = text_q.pop_front();
                    if (o_text_char !== want.ch) begin
                        $error("text_char: expected %h, got %h", want.ch, o_text_char);
                        errors++;
                    end
                    if (o_last !== want.is_last) begin
                        $error("last: expected %b, got %b", want.is_last, o_last);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                encode_item(i_op, i_data_byte);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("intel_hex_record_encoder_tb: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: row wrapping the 32-bit space, walking bits, flushes
        write_base(32'hFFFF_FFF8);
        queue_item(OP_FINISH, 8'h00);
        queue_item(OP_BYTE, 8'h00);
        queue_item(OP_BYTE, 8'hFF);
        for (int i = 0; i < 8; i++) begin
            queue_item(OP_BYTE, 8'h01 << i);
        end
        for (int i = 0; i < 6; i++) begin
            queue_item(OP_BYTE, ~(8'h01 << i));
        end
        queue_item(OP_BYTE, 8'hA5);
        queue_item(OP_BYTE, 8'h5A);
        queue_item(OP_BYTE, 8'hC3);
        queue_item(OP_FINISH, 8'hFF);
        queue_item(OP_FINISH, 8'h00);
        // sender holds off until all text has drained
        settle();

        write_base(32'h0000_0000);
        random_phase(38, 20);
        settle();
        write_base(32'hFFFF_FFFF);
        random_phase(38, 6);
        settle();
        write_base({16'($urandom_range(0, 65535)), 16'hFFF0 + 16'($urandom_range(0, 15))});
        random_phase(38, 40);
        settle();
        write_base($urandom);
        random_phase(38, 10);
        settle();
        write_base(32'h7FFF_FFFC);
        random_phase(38, 25);
        settle();
        write_base($urandom);
        random_phase(38, 3);
        settle();
        write_base({16'hFFFF, 16'($urandom_range(0, 65535))});
        random_phase(38, 30);
        settle();
        quiet = 1'b1;
        write_base($urandom);
        random_phase(38, 15);

        while (pend_q.size() != 0 || i_in_valid || text_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("intel_hex_record_encoder_tb: done, clean");
        end else begin
            $display("intel_hex_record_encoder_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_ucode_rom.sv
hw/rtl/ihex_seq.sv
hw/rtl/ihex_dp.sv
hw/rtl/intel_hex_record_encoder.sv
sim/intel_hex_record_encoder_tb.sv
